@@ src/smavg_pkg.sv @@
package smavg_pkg;

   localparam int GROUP_CAPACITY_DEF = 16;

   localparam int DATE_W  = 64;
   localparam int VALUE_W = 20;
   localparam int KIND_W  = 2;
   localparam int WIN_W   = 5;
   // Window sum of up to 31 values of VALUE_W bits.
   localparam int SUM_W   = VALUE_W + WIN_W;
   localparam int DATA_W  = DATE_W + 2 * VALUE_W;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;

   localparam logic             REG_WINDOW_LENGTH = 1'b0;
   localparam logic [WIN_W-1:0] WINDOW_RESET      = 5'd1;

   typedef struct packed {
      logic [VALUE_W-1:0] second_value;
      logic [VALUE_W-1:0] first_value;
      logic [DATE_W-1:0]  date_key;
   } rec_type;

   typedef struct packed {
      logic load;       // store an accepted record
      logic clear;      // empty both groups, back to the open group
      logic grp_next;   // move to the close group
      logic i_clear;
      logic rd_i;       // read slot i, point j past it
      logic cap_i;      // capture slot i as first candidate, read slot j
      logic scan;       // compare slot j, advance j
      logic wr_best;    // write the minimum into slot i
      logic wr_i;       // write old slot i into the minimum's slot
      logic i_inc;
      logic p_init;
      logic sum_init;
      logic sum_acc;
      logic div_start;
      logic out_load;
      logic p_inc;
   } cmd_type;

   typedef struct packed {
      logic grp;
      logic i_last;
      logic j_last;
      logic best_is_i;
      logic no_results;
      logic q_last;
      logic div_done;
      logic out_free;
      logic p_last;
   } status_type;

endpackage

@@ src/smavg_ctrl.sv @@
module smavg_ctrl
   import smavg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  status_type st,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SORT_I    = 4'd1;
   localparam logic [3:0] S_SORT_CAP  = 4'd2;
   localparam logic [3:0] S_SORT_SCAN = 4'd3;
   localparam logic [3:0] S_SWAP_A    = 4'd4;
   localparam logic [3:0] S_SWAP_B    = 4'd5;
   localparam logic [3:0] S_AVG_CHK   = 4'd6;
   localparam logic [3:0] S_SUM_GO    = 4'd7;
   localparam logic [3:0] S_SUM       = 4'd8;
   localparam logic [3:0] S_DIV_GO    = 4'd9;
   localparam logic [3:0] S_DIV       = 4'd10;
   localparam logic [3:0] S_OUT       = 4'd11;
   localparam logic [3:0] S_FINISH    = 4'd12;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  cmd.i_clear = 1'b1;
                  state_in    = S_SORT_I;
               end
            end
         end
         S_SORT_I: begin
            if (st.i_last) begin
               state_in = S_AVG_CHK;
            end else begin
               cmd.rd_i = 1'b1;
               state_in = S_SORT_CAP;
            end
         end
         S_SORT_CAP: begin
            cmd.cap_i = 1'b1;
            state_in  = S_SORT_SCAN;
         end
         S_SORT_SCAN: begin
            cmd.scan = 1'b1;
            if (st.j_last) begin
               state_in = S_SWAP_A;
            end
         end
         S_SWAP_A: begin
            if (st.best_is_i) begin
               cmd.i_inc = 1'b1;
               state_in  = S_SORT_I;
            end else begin
               cmd.wr_best = 1'b1;
               state_in    = S_SWAP_B;
            end
         end
         S_SWAP_B: begin
            cmd.wr_i  = 1'b1;
            cmd.i_inc = 1'b1;
            state_in  = S_SORT_I;
         end
         S_AVG_CHK: begin
            if (st.no_results) begin
               if (st.grp) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.grp_next = 1'b1;
                  cmd.i_clear  = 1'b1;
                  state_in     = S_SORT_I;
               end
            end else begin
               cmd.p_init = 1'b1;
               state_in   = S_SUM_GO;
            end
         end
         S_SUM_GO: begin
            cmd.sum_init = 1'b1;
            state_in     = S_SUM;
         end
         S_SUM: begin
            cmd.sum_acc = 1'b1;
            if (st.q_last) begin
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (st.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               if (!st.p_last) begin
                  cmd.p_inc = 1'b1;
                  state_in  = S_SUM_GO;
               end else if (st.grp) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.grp_next = 1'b1;
                  cmd.i_clear  = 1'b1;
                  state_in     = S_SORT_I;
               end
            end
         end
         S_FINISH: begin
            cmd.clear = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/smavg_dp.sv @@
module smavg_dp
   import smavg_pkg::*;
#(
   parameter int GROUP_CAPACITY = GROUP_CAPACITY_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          st,
   input  logic [WIN_W-1:0]    window,
   input  logic [DATA_W-1:0]   req_tdata,
   input  logic [KIND_W-1:0]   req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,
   output logic                rsp_tuser,
   output logic                rsp_tlast
);

   localparam int DEPTH = 2 * GROUP_CAPACITY;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(GROUP_CAPACITY + 1);
   localparam int CMPW  = (WIN_W > CW) ? WIN_W + 1 : CW + 1;
   localparam int DCW   = $clog2(SUM_W + 1);

   rec_type rec_mem_ff [DEPTH];
   rec_type rd_ff;

   logic [CW-1:0]    open_cnt_ff, close_cnt_ff;
   logic             grp_ff;
   logic [CW-1:0]    i_ff, j_ff, best_ff, p_ff;
   logic [WIN_W-1:0] q_ff;
   rec_type          rec_i_ff, best_rec_ff;
   logic [SUM_W-1:0] sum1_ff, sum2_ff;
   logic [DATE_W-1:0] date_ff;

   logic             div_busy_ff;
   logic [DCW-1:0]   div_cnt_ff;
   logic [SUM_W-1:0] n1_ff, n2_ff;
   logic [WIN_W-1:0] r1_ff, r2_ff;

   logic             rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic             rsp_kind_ff, rsp_last_ff;

   rec_type          in_rec;
   logic [CW-1:0]    cnt_cur;
   logic [AW-1:0]    base;
   logic [AW-1:0]    rd_addr, wr_addr;
   rec_type          wr_data;
   logic             wr_en;
   logic             open_ok, close_ok, close_has;
   logic [CW-1:0]    p_back;

   logic [WIN_W:0]   t1, t2;
   logic             qb1, qb2;
   logic [WIN_W:0]   win_ext;

   assign in_rec  = rec_type'(req_tdata);
   assign cnt_cur = grp_ff ? close_cnt_ff : open_cnt_ff;
   assign base    = grp_ff ? AW'(GROUP_CAPACITY) : '0;
   assign open_ok  = (req_tuser == KIND_OPEN)  && (open_cnt_ff  < CW'(GROUP_CAPACITY));
   assign close_ok = (req_tuser == KIND_CLOSE) && (close_cnt_ff < CW'(GROUP_CAPACITY));
   assign close_has = (window != '0) && (CMPW'(window) <= CMPW'(close_cnt_ff));
   assign p_back   = p_ff - CW'(q_ff) - CW'(1);

   // status
   assign st.grp        = grp_ff;
   assign st.i_last     = (CMPW'(i_ff) + CMPW'(1)) >= CMPW'(cnt_cur);
   assign st.j_last     = (CMPW'(j_ff) + CMPW'(1)) >= CMPW'(cnt_cur);
   assign st.best_is_i  = (best_ff == i_ff);
   assign st.no_results = (window == '0) || (CMPW'(window) > CMPW'(cnt_cur));
   assign st.q_last     = (CMPW'(q_ff) + CMPW'(1)) >= CMPW'(window);
   assign st.div_done   = !div_busy_ff;
   assign st.out_free   = !rsp_valid_ff;
   assign st.p_last     = (CMPW'(p_ff) + CMPW'(1)) >= CMPW'(cnt_cur);

   // read address
   always_comb begin
      rd_addr = base + AW'(j_ff);
      if (cmd.rd_i) begin
         rd_addr = base + AW'(i_ff);
      end else if (cmd.scan) begin
         rd_addr = base + AW'(j_ff) + AW'(1);
      end else if (cmd.sum_init) begin
         rd_addr = base + AW'(p_ff);
      end else if (cmd.sum_acc) begin
         rd_addr = base + AW'(p_back);
      end
   end

   // write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(open_cnt_ff);
      wr_data = in_rec;
      if (cmd.load && open_ok) begin
         wr_en = 1'b1;
      end else if (cmd.load && close_ok) begin
         wr_en   = 1'b1;
         wr_addr = AW'(GROUP_CAPACITY) + AW'(close_cnt_ff);
      end else if (cmd.wr_best) begin
         wr_en   = 1'b1;
         wr_addr = base + AW'(i_ff);
         wr_data = best_rec_ff;
      end else if (cmd.wr_i) begin
         wr_en   = 1'b1;
         wr_addr = base + AW'(best_ff);
         wr_data = rec_i_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= rec_mem_ff[rd_addr];
   end

   // group counts and group select
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         open_cnt_ff  <= '0;
         close_cnt_ff <= '0;
         grp_ff       <= 1'b0;
      end else begin
         if (cmd.load && open_ok) begin
            open_cnt_ff <= open_cnt_ff + CW'(1);
         end
         if (cmd.load && close_ok) begin
            close_cnt_ff <= close_cnt_ff + CW'(1);
         end
         if (cmd.grp_next) begin
            grp_ff <= 1'b1;
         end
      end
   end

   // selection sort indices
   always_ff @(posedge clock) begin
      if (cmd.i_clear) begin
         i_ff <= '0;
      end else if (cmd.i_inc) begin
         i_ff <= i_ff + CW'(1);
      end
      if (cmd.rd_i) begin
         j_ff <= i_ff + CW'(1);
      end else if (cmd.scan) begin
         j_ff <= j_ff + CW'(1);
      end
      if (cmd.cap_i) begin
         rec_i_ff    <= rd_ff;
         best_rec_ff <= rd_ff;
         best_ff     <= i_ff;
      end else if (cmd.scan && (best_rec_ff.date_key > rd_ff.date_key)) begin
         best_rec_ff <= rd_ff;
         best_ff     <= j_ff;
      end
   end

   // window sums
   always_ff @(posedge clock) begin
      if (cmd.p_init) begin
         p_ff <= CW'(window - WIN_W'(1));
      end else if (cmd.p_inc) begin
         p_ff <= p_ff + CW'(1);
      end
      if (cmd.sum_init) begin
         q_ff    <= '0;
         sum1_ff <= '0;
         sum2_ff <= '0;
      end else if (cmd.sum_acc) begin
         q_ff    <= q_ff + WIN_W'(1);
         sum1_ff <= sum1_ff + SUM_W'(rd_ff.first_value);
         sum2_ff <= sum2_ff + SUM_W'(rd_ff.second_value);
         if (q_ff == '0) begin
            date_ff <= rd_ff.date_key;
         end
      end
   end

   // restoring divider, one quotient bit per cycle for both sums
   assign win_ext = {1'b0, window};
   assign t1  = {r1_ff, n1_ff[SUM_W-1]};
   assign t2  = {r2_ff, n2_ff[SUM_W-1]};
   assign qb1 = (t1 >= win_ext);
   assign qb2 = (t2 >= win_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= DCW'(SUM_W);
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - DCW'(1);
         if (div_cnt_ff == DCW'(1)) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         n1_ff <= sum1_ff;
         n2_ff <= sum2_ff;
         r1_ff <= '0;
         r2_ff <= '0;
      end else if (div_busy_ff) begin
         n1_ff <= {n1_ff[SUM_W-2:0], qb1};
         n2_ff <= {n2_ff[SUM_W-2:0], qb2};
         r1_ff <= qb1 ? WIN_W'(t1 - win_ext) : t1[WIN_W-1:0];
         r2_ff <= qb2 ? WIN_W'(t2 - win_ext) : t2[WIN_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {n2_ff[VALUE_W-1:0], n1_ff[VALUE_W-1:0], date_ff};
         rsp_kind_ff <= grp_ff;
         rsp_last_ff <= st.p_last && (grp_ff || !close_has);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ src/sorted_moving_average_two_series_unit.sv @@
// Sorted moving average over an open and a close series.
// req_* stream: one record per transaction; tdata holds date key, first value
// and second value, tuser the record kind (open, close, other), tlast ends the
// data set. Records load one per cycle; each group keeps its first
// GROUP_CAPACITY records, the rest and records of other kinds are dropped.
// After the tlast transaction the input stalls (req_tready low) while each
// group is selection-sorted by date in the shared store: one compare per
// cycle, n*(n-1)/2 compares for n records, plus S_SORT_I, S_SORT_CAP and
// S_SWAP_A per slot, S_SWAP_B per swap. Each sorted group is then averaged.
// rsp_* stream: one transaction per window position, open series first,
// tlast on the final one. Each result takes one store read per window
// position, 25 shift-subtract divider steps and the S_SUM_GO, S_DIV_GO and
// S_OUT control states; the single store read port and the divider set its cost.
// A stalled receiver holds the result register; the next result is computed
// meanwhile and is held until the register drains.
// csr_* port: window_length at byte address 0, written while idle by the user (unchecked).
// Reset empties both groups, idles the controller, drops any pending result
// and sets window_length to 1. Store contents are not cleared.
module sorted_moving_average_two_series_unit
   import smavg_pkg::*;
#(
   parameter int GROUP_CAPACITY = GROUP_CAPACITY_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,   // date_key, first_value, second_value
   input  logic [KIND_W-1:0]   req_tuser,   // record_kind
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,   // out_date_key, first_average, second_average
   output logic                rsp_tuser,   // out_kind
   output logic                rsp_tlast,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   cmd_type          cmd;
   status_type       st;
   logic [WIN_W-1:0] window_ff, window_in;
   logic             csr_wr;

   // Register file: a single word, decoded on the word index.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      window_in = window_ff;
      if (csr_wr && (csr_paddr[2] == REG_WINDOW_LENGTH)) begin
         window_in = csr_pwdata[WIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_WINDOW_LENGTH) ?
                       {{(CSR_DW-WIN_W){1'b0}}, window_ff} : '0;

   // Sequencer: load, sort and average phases.
   smavg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   // Store, sort registers, window accumulators, divider and result register.
   smavg_dp #(
      .GROUP_CAPACITY (GROUP_CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .window     (window_ff),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
